@@ sv/rmj_pkg.sv @@
// ----------------------------------------------------------------------------
// Radar measurement Jacobian package
// Shared transaction types, stage records and widths for the Jacobian pipeline.
// ----------------------------------------------------------------------------
package rmj_pkg;

   // Default number of fraction bits of the fixed-point format.
   localparam int FRAC_BITS_DEF = 16;

   // Field and intermediate widths.
   localparam int VAL_W  = 32;   // input and output values, root, quotient
   localparam int SQ_W   = 64;   // r2 and cross term
   localparam int D3_W   = 96;   // r2 * r and the rate numerators
   localparam int REM_W  = 34;   // square-root partial remainder
   localparam int Q_W    = 32;   // quotient bits produced by a divider
   localparam int DIV_LAT = Q_W + 2;  // length of the valid and degenerate delay lines

   // Input transaction: one constant-velocity state.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   // Result transaction: nonzero Jacobian entries and the degenerate flag.
   typedef struct packed {
      logic signed [31:0] range_d_px;
      logic signed [31:0] range_d_py;
      logic signed [31:0] bearing_d_px;
      logic signed [31:0] bearing_d_py;
      logic signed [31:0] rate_d_px;
      logic signed [31:0] rate_d_py;
      logic signed [31:0] rate_d_vx;
      logic signed [31:0] rate_d_vy;
      logic               degenerate;
   } rsp_type;

   // Front-end result: magnitudes, r2 and cross term in sign-magnitude form.
   typedef struct packed {
      logic              valid;
      logic              degen;
      logic              sp;
      logic              sq;
      logic              sc;
      logic [VAL_W-1:0]  mp;
      logic [VAL_W-1:0]  mq;
      logic [SQ_W-1:0]   s;
      logic [SQ_W-1:0]   mc;
   } front_type;

   // Square-root result travels with the front-end record.
   typedef struct packed {
      front_type         fr;
      logic [VAL_W-1:0]  r;
   } root_type;

   // Everything the dividers need.
   typedef struct packed {
      logic              valid;
      logic              degen;
      logic              sp;
      logic              sq;
      logic              sc;
      logic [VAL_W-1:0]  mp;
      logic [VAL_W-1:0]  mq;
      logic [VAL_W-1:0]  r;
      logic [SQ_W-1:0]   s;
      logic [D3_W-1:0]   den3;
      logic [D3_W-1:0]   nq;
      logic [D3_W-1:0]   np;
   } prod_type;

endpackage

@@ sv/rmj_front.sv @@
// ----------------------------------------------------------------------------
// Jacobian front end
// Three stages: sign split, 32x32 products, then r2, cross term and the
// degenerate test.
// ----------------------------------------------------------------------------
module rmj_front #(
   parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rmj_pkg::req_type   in_data,
   output rmj_pkg::front_type out_data
);
   import rmj_pkg::*;

   // Smallest raw r2 that is not treated as lying at the origin.
   localparam logic [SQ_W-1:0] THR =
      ((64'd1 << (2 * FRAC_BITS)) / 64'd100000) + 64'd1;

   // Stage 1 registers: magnitudes and signs.
   logic             v1_ff;
   logic [VAL_W-1:0] mp1_ff, mq1_ff, mvx1_ff, mvy1_ff;
   logic             sp1_ff, sq1_ff, svx1_ff, svy1_ff;

   // Stage 2 registers: products.
   logic             v2_ff;
   logic [SQ_W-1:0]  pp2_ff, qq2_ff, a2_ff, b2_ff;
   logic [VAL_W-1:0] mp2_ff, mq2_ff;
   logic             sp2_ff, sq2_ff, sa2_ff, sb2_ff;

   // Stage 3 register.
   front_type        fr_ff, fr_in;
   logic [SQ_W-1:0]  s3;

   // Control bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         fr_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         fr_ff.valid <= fr_in.valid;
      end
   end

   // Stage 1: split each value into sign and magnitude.
   always_ff @(posedge clock) begin
      if (en) begin
         sp1_ff  <= in_data.pos_x[31];
         sq1_ff  <= in_data.pos_y[31];
         svx1_ff <= in_data.vel_x[31];
         svy1_ff <= in_data.vel_y[31];
         mp1_ff  <= in_data.pos_x[31] ? VAL_W'(-in_data.pos_x) : VAL_W'(in_data.pos_x);
         mq1_ff  <= in_data.pos_y[31] ? VAL_W'(-in_data.pos_y) : VAL_W'(in_data.pos_y);
         mvx1_ff <= in_data.vel_x[31] ? VAL_W'(-in_data.vel_x) : VAL_W'(in_data.vel_x);
         mvy1_ff <= in_data.vel_y[31] ? VAL_W'(-in_data.vel_y) : VAL_W'(in_data.vel_y);
      end
   end

   // Stage 2: squares and the two halves of the cross term.
   always_ff @(posedge clock) begin
      if (en) begin
         pp2_ff <= SQ_W'(mp1_ff) * SQ_W'(mp1_ff);
         qq2_ff <= SQ_W'(mq1_ff) * SQ_W'(mq1_ff);
         a2_ff  <= SQ_W'(mvx1_ff) * SQ_W'(mq1_ff);
         b2_ff  <= SQ_W'(mvy1_ff) * SQ_W'(mp1_ff);
         mp2_ff <= mp1_ff;
         mq2_ff <= mq1_ff;
         sp2_ff <= sp1_ff;
         sq2_ff <= sq1_ff;
         sa2_ff <= svx1_ff ^ sq1_ff;
         sb2_ff <= ~(svy1_ff ^ sp1_ff);
      end
   end

   // Stage 3: r2, signed cross term vx*py - vy*px and the degenerate test.
   assign s3 = pp2_ff + qq2_ff;

   always_comb begin
      fr_in       = '0;
      fr_in.valid = v2_ff;
      fr_in.sp    = sp2_ff;
      fr_in.sq    = sq2_ff;
      fr_in.mp    = mp2_ff;
      fr_in.mq    = mq2_ff;
      fr_in.s     = s3;
      fr_in.degen = (s3 < THR) || (mp2_ff == '0) || (mq2_ff == '0);
      if (sa2_ff == sb2_ff) begin
         fr_in.mc = a2_ff + b2_ff;
         fr_in.sc = sa2_ff;
      end else if (a2_ff >= b2_ff) begin
         fr_in.mc = a2_ff - b2_ff;
         fr_in.sc = sa2_ff;
      end else begin
         fr_in.mc = b2_ff - a2_ff;
         fr_in.sc = sb2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff.degen <= fr_in.degen;
         fr_ff.sp    <= fr_in.sp;
         fr_ff.sq    <= fr_in.sq;
         fr_ff.sc    <= fr_in.sc;
         fr_ff.mp    <= fr_in.mp;
         fr_ff.mq    <= fr_in.mq;
         fr_ff.s     <= fr_in.s;
         fr_ff.mc    <= fr_in.mc;
      end
   end

   assign out_data = fr_ff;

endmodule

@@ sv/rmj_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, 32 stages, floor(sqrt(r2)) of the 64-bit r2.
// ----------------------------------------------------------------------------
module rmj_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  rmj_pkg::front_type in_data,
   output rmj_pkg::root_type  out_data
);
   import rmj_pkg::*;

   front_type        fr_ff  [0:VAL_W-1];
   logic [VAL_W-1:0] q_ff   [0:VAL_W-1];
   logic [REM_W-1:0] rem_ff [0:VAL_W-2];

   genvar k;
   for (k = 0; k < VAL_W; k++) begin : g_stage
      front_type        fr_prev;
      logic [VAL_W-1:0] q_prev;
      logic [REM_W-1:0] rem_prev;
      logic [REM_W+1:0] rem_t, trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign fr_prev  = in_data;
         assign q_prev   = '0;
         assign rem_prev = '0;
      end else begin : g_next
         assign fr_prev  = fr_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign rem_prev = rem_ff[k-1];
      end

      // Bring down the next two bits of r2 and try the next root bit.
      assign rem_t = {rem_prev, fr_prev.s[SQ_W-1-2*k -: 2]};
      assign trial = {2'b00, q_prev, 2'b01};
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            fr_ff[k].valid <= 1'b0;
         end else if (en) begin
            fr_ff[k].valid <= fr_prev.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            fr_ff[k].degen <= fr_prev.degen;
            fr_ff[k].sp    <= fr_prev.sp;
            fr_ff[k].sq    <= fr_prev.sq;
            fr_ff[k].sc    <= fr_prev.sc;
            fr_ff[k].mp    <= fr_prev.mp;
            fr_ff[k].mq    <= fr_prev.mq;
            fr_ff[k].s     <= fr_prev.s;
            fr_ff[k].mc    <= fr_prev.mc;
            q_ff[k]        <= {q_prev[VAL_W-2:0], ge};
         end
      end

      // The last stage needs no remainder.
      if (k < VAL_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
            end
         end
      end
   end

   assign out_data.fr = fr_ff[VAL_W-1];
   assign out_data.r  = q_ff[VAL_W-1];

endmodule

@@ sv/rmj_prod.sv @@
// ----------------------------------------------------------------------------
// Denominator and numerator products
// Two stages: 32x32 partial products of r2*r, py*C and px*C, then their sums.
// ----------------------------------------------------------------------------
module rmj_prod (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  rmj_pkg::root_type in_data,
   output rmj_pkg::prod_type out_data
);
   import rmj_pkg::*;

   // Stage 1: partial products and carried fields.
   logic             v1_ff, dg1_ff, sp1_ff, sq1_ff, sc1_ff;
   logic [VAL_W-1:0] mp1_ff, mq1_ff, r1_ff;
   logic [SQ_W-1:0]  s1_ff;
   logic [SQ_W-1:0]  sr_lo_ff, sr_hi_ff, nq_lo_ff, nq_hi_ff, np_lo_ff, np_hi_ff;

   prod_type         pr_ff;

   // Control bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         pr_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff       <= in_data.fr.valid;
         pr_ff.valid <= v1_ff;
      end
   end

   // Stage 1: split each wide product into two 32x32 multiplies.
   always_ff @(posedge clock) begin
      if (en) begin
         sr_lo_ff <= SQ_W'(in_data.fr.s[31:0])  * SQ_W'(in_data.r);
         sr_hi_ff <= SQ_W'(in_data.fr.s[63:32]) * SQ_W'(in_data.r);
         nq_lo_ff <= SQ_W'(in_data.fr.mc[31:0])  * SQ_W'(in_data.fr.mq);
         nq_hi_ff <= SQ_W'(in_data.fr.mc[63:32]) * SQ_W'(in_data.fr.mq);
         np_lo_ff <= SQ_W'(in_data.fr.mc[31:0])  * SQ_W'(in_data.fr.mp);
         np_hi_ff <= SQ_W'(in_data.fr.mc[63:32]) * SQ_W'(in_data.fr.mp);
         dg1_ff   <= in_data.fr.degen;
         sp1_ff   <= in_data.fr.sp;
         sq1_ff   <= in_data.fr.sq;
         sc1_ff   <= in_data.fr.sc;
         mp1_ff   <= in_data.fr.mp;
         mq1_ff   <= in_data.fr.mq;
         r1_ff    <= in_data.r;
         s1_ff    <= in_data.fr.s;
      end
   end

   // Stage 2: combine the partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff.den3  <= D3_W'(sr_lo_ff) + {sr_hi_ff, 32'b0};
         pr_ff.nq    <= D3_W'(nq_lo_ff) + {nq_hi_ff, 32'b0};
         pr_ff.np    <= D3_W'(np_lo_ff) + {np_hi_ff, 32'b0};
         pr_ff.degen <= dg1_ff;
         pr_ff.sp    <= sp1_ff;
         pr_ff.sq    <= sq1_ff;
         pr_ff.sc    <= sc1_ff;
         pr_ff.mp    <= mp1_ff;
         pr_ff.mq    <= mq1_ff;
         pr_ff.r     <= r1_ff;
         pr_ff.s     <= s1_ff;
      end
   end

   assign out_data = pr_ff;

endmodule

@@ sv/rmj_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Overflow check, 32 restoring-division stages, then round half away from
// zero and saturate to a signed 32-bit result.
// ----------------------------------------------------------------------------
module rmj_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic             neg,
   output logic [31:0]      quo
);
   import rmj_pkg::*;

   localparam int HI_W  = NUM_W - Q_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [CMP_W-1:0] hi_ext, den_ext;
   logic             ovf_in;

   logic [DEN_W-1:0] rem_ff [0:Q_W];
   logic [DEN_W-1:0] den_ff [0:Q_W];
   logic             neg_ff [0:Q_W];
   logic             ovf_ff [0:Q_W];
   logic [Q_W-1:0]   lo_ff  [0:Q_W-1];
   logic [Q_W-1:0]   q_ff   [1:Q_W];

   logic             rnd;
   logic [Q_W:0]     mag, lim, sel;
   logic [31:0]      quo_ff, quo_in;

   // The quotient has more than 32 bits when the upper part reaches the divisor.
   assign hi_ext  = CMP_W'(num[NUM_W-1:Q_W]);
   assign den_ext = CMP_W'(den);
   assign ovf_in  = hi_ext >= den_ext;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num[NUM_W-1:Q_W]);
         lo_ff[0]  <= num[Q_W-1:0];
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         ovf_ff[0] <= ovf_in;
      end
   end

   // One quotient bit per stage.
   genvar i;
   for (i = 1; i <= Q_W; i++) begin : g_stage
      logic [DEN_W:0] t, d;
      logic           ge;
      logic [Q_W-1:0] q_prev;

      assign t  = {rem_ff[i-1], lo_ff[i-1][Q_W-1]};
      assign d  = {1'b0, den_ff[i-1]};
      assign ge = t >= d;

      if (i == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? DEN_W'(t - d) : DEN_W'(t);
            q_ff[i]   <= {q_prev[Q_W-2:0], ge};
            den_ff[i] <= den_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end

      if (i < Q_W) begin : g_lo
         always_ff @(posedge clock) begin
            if (en) begin
               lo_ff[i] <= lo_ff[i-1] << 1;
            end
         end
      end
   end

   // Round half away from zero, saturate, apply the sign.
   assign rnd = {rem_ff[Q_W], 1'b0} >= {1'b0, den_ff[Q_W]};
   assign mag = {1'b0, q_ff[Q_W]} + (Q_W + 1)'(rnd);
   assign lim = neg_ff[Q_W] ? 33'h080000000 : 33'h07FFFFFFF;
   assign sel = (ovf_ff[Q_W] || (mag > lim)) ? lim : mag;
   assign quo_in = neg_ff[Q_W] ? 32'(33'd0 - sel) : 32'(sel);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

@@ sv/radar_measurement_jacobian.sv @@
// ----------------------------------------------------------------------------
// Radar measurement Jacobian
// Nonzero entries of the range, bearing and range-rate Jacobian of a
// constant-velocity state, in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// The block takes one state transaction per cycle while the output buffer
// has room and returns one result transaction for each, in order, through
// three front-end stages, a 32-stage square root, two product stages, six
// 34-stage dividers running side by side, and a two-entry output buffer. A
// stalled result port holds the pipeline once the output buffer is full; up
// to then new transactions keep entering.
module radar_measurement_jacobian #(
   parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmj_pkg::rsp_type rsp_data
);
   import rmj_pkg::*;

   logic       adv;
   front_type  fr;
   root_type   rt;
   prod_type   pr;

   logic [31:0] q_rpx, q_rpy, q_bpx, q_bpy, q_tpx, q_tpy;
   logic        dv_ff [0:DIV_LAT-1];
   logic        dg_ff [0:DIV_LAT-1];

   rsp_type     res;
   rsp_type     mem_ff [0:1];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   // The pipeline moves while the output buffer has room.
   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;

   rmj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_data (fr)
   );

   rmj_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_data  (fr),
      .out_data (rt)
   );

   rmj_prod u_prod (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_data  (rt),
      .out_data (pr)
   );

   // Range derivatives px/r and py/r.
   rmj_div #(.NUM_W(VAL_W + FRAC_BITS), .DEN_W(VAL_W)) u_div_rpx (
      .clock (clock), .en (adv),
      .num ({pr.mp, {FRAC_BITS{1'b0}}}), .den (pr.r), .neg (pr.sp), .quo (q_rpx)
   );

   rmj_div #(.NUM_W(VAL_W + FRAC_BITS), .DEN_W(VAL_W)) u_div_rpy (
      .clock (clock), .en (adv),
      .num ({pr.mq, {FRAC_BITS{1'b0}}}), .den (pr.r), .neg (pr.sq), .quo (q_rpy)
   );

   // Bearing derivatives -py/r2 and px/r2.
   rmj_div #(.NUM_W(VAL_W + 2 * FRAC_BITS), .DEN_W(SQ_W)) u_div_bpx (
      .clock (clock), .en (adv),
      .num ({pr.mq, {(2 * FRAC_BITS){1'b0}}}), .den (pr.s), .neg (~pr.sq), .quo (q_bpx)
   );

   rmj_div #(.NUM_W(VAL_W + 2 * FRAC_BITS), .DEN_W(SQ_W)) u_div_bpy (
      .clock (clock), .en (adv),
      .num ({pr.mp, {(2 * FRAC_BITS){1'b0}}}), .den (pr.s), .neg (pr.sp), .quo (q_bpy)
   );

   // Range-rate derivatives py*C/r^3 and -px*C/r^3.
   rmj_div #(.NUM_W(D3_W + FRAC_BITS), .DEN_W(D3_W)) u_div_tpx (
      .clock (clock), .en (adv),
      .num ({pr.nq, {FRAC_BITS{1'b0}}}), .den (pr.den3), .neg (pr.sq ^ pr.sc),
      .quo (q_tpx)
   );

   rmj_div #(.NUM_W(D3_W + FRAC_BITS), .DEN_W(D3_W)) u_div_tpy (
      .clock (clock), .en (adv),
      .num ({pr.np, {FRAC_BITS{1'b0}}}), .den (pr.den3), .neg (~(pr.sp ^ pr.sc)),
      .quo (q_tpy)
   );

   // Valid and degenerate bits travel beside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_LAT; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= pr.valid;
         for (int j = 1; j < DIV_LAT; j++) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dg_ff[0] <= pr.degen;
         for (int j = 1; j < DIV_LAT; j++) begin
            dg_ff[j] <= dg_ff[j-1];
         end
      end
   end

   // Assemble the result; a degenerate state forces every entry to zero.
   always_comb begin
      res = '0;
      if (dg_ff[DIV_LAT-1]) begin
         res.degenerate = 1'b1;
      end else begin
         res.range_d_px   = q_rpx;
         res.range_d_py   = q_rpy;
         res.bearing_d_px = q_bpx;
         res.bearing_d_py = q_bpy;
         res.rate_d_px    = q_tpx;
         res.rate_d_py    = q_tpy;
         res.rate_d_vx    = q_rpx;
         res.rate_d_vy    = q_rpy;
      end
   end

   // Two-entry output buffer.
   assign push = adv && dv_ff[DIV_LAT-1];
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];

endmodule

@@ sv/rmj_checker.sv @@
// ----------------------------------------------------------------------------
// Radar measurement Jacobian checker
// Port-level properties of the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module rmj_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rmj_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rmj_pkg::rsp_type rsp_data
);

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result transaction holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A degenerate result carries zero range, bearing and position range-rate entries.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.range_d_px == 0 && rsp_data.range_d_py == 0 &&
         rsp_data.bearing_d_px == 0 && rsp_data.bearing_d_py == 0 &&
         rsp_data.rate_d_px == 0 && rsp_data.rate_d_py == 0)
      else $error("degenerate result with nonzero entries");

   // The velocity entries of the range-rate row equal the range row.
   a_rate_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.rate_d_vx == rsp_data.range_d_px &&
                    rsp_data.rate_d_vy == rsp_data.range_d_py)
      else $error("range-rate velocity entries differ from range row");

   // A waiting request transaction stays offered with the same state.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request dropped or changed");

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (.*);
